### design/gdf_pkg.sv
// gdf_pkg: widths, codes and shared types of the gapped dipeptide frequency unit
// no dependencies; imported by the channel interfaces and every module
`default_nettype none

package gdf_pkg;

   // residue alphabet, index order A R N D C Q E G H I L K M F P S T W Y V
   localparam int unsigned RESIDUE_COUNT = 20;
   localparam int unsigned DEF_MAX_LENGTH = 4096;

   localparam int unsigned KIND_W = 1;
   localparam int unsigned POS_W = 12;
   localparam int unsigned RES_W = 5;
   localparam int unsigned WEIGHT_W = 16;
   localparam int unsigned GAP_W = 12;
   localparam int unsigned LEN_W = 13;
   localparam int unsigned PROD_W = 2 * WEIGHT_W;
   localparam int unsigned SUM_W = 44;

   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [KIND_W-1:0] KIND_LOAD = 1'b0;
   localparam logic [KIND_W-1:0] KIND_QUERY = 1'b1;

   // register index as seen on paddr[2]
   localparam logic CSR_SEQUENCE_LENGTH = 1'b0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HEAD,
      ST_TAIL,
      ST_MUL,
      ST_ACC,
      ST_DONE
   } gdf_state_type;

   typedef struct packed {
      logic clear;
      logic load_head;
      logic mult;
      logic accumulate;
   } gdf_mac_ctrl_type;

endpackage

`default_nettype wire

### design/gdf_if.sv
// gdf_req_if and gdf_rsp_if: valid/ready channels for request and result transfers
// depends on gdf_pkg for the field widths
`default_nettype none

interface gdf_req_if import gdf_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [POS_W-1:0]    position;
   logic [RES_W-1:0]    residue;
   logic [WEIGHT_W-1:0] weight;
   logic [RES_W-1:0]    head_residue;
   logic [RES_W-1:0]    tail_residue;
   logic [GAP_W-1:0]    gap_length;

   modport source (
      output valid, kind, position, residue, weight, head_residue, tail_residue, gap_length,
      input  ready
   );
   modport sink (
      input  valid, kind, position, residue, weight, head_residue, tail_residue, gap_length,
      output ready
   );
endinterface

interface gdf_rsp_if import gdf_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [SUM_W-1:0] frequency_sum;

   modport source (output valid, frequency_sum, input ready);
   modport sink (input valid, frequency_sum, output ready);
endinterface

`default_nettype wire

### design/gdf_mac_unit.sv
// gdf_mac_unit: shared multiply-accumulate datapath stepped by the query sequencer
// depends on gdf_pkg for widths and the control struct
`default_nettype none

module gdf_mac_unit import gdf_pkg::*; (
   input  wire logic                clock,
   input  wire gdf_mac_ctrl_type    ctrl,
   input  wire logic [WEIGHT_W-1:0] rdata,
   output logic      [SUM_W-1:0]    acc
);

   logic [WEIGHT_W-1:0] head_ff;
   logic [PROD_W-1:0]   product_ff;
   logic [SUM_W-1:0]    acc_ff;

   always_ff @(posedge clock) begin
      if (ctrl.load_head) begin
         head_ff <= rdata;
      end
      if (ctrl.mult) begin
         product_ff <= head_ff * rdata;
      end
      if (ctrl.clear) begin
         acc_ff <= '0;
      end else if (ctrl.accumulate) begin
         acc_ff <= acc_ff + SUM_W'(product_ff);
      end
   end

   assign acc = acc_ff;

endmodule

`default_nettype wire

### design/gapped_dipeptide_frequency_unit.sv
// gapped_dipeptide_frequency_unit: profile memory, query sequencer and result register
// depends on gdf_pkg, gdf_if (request and result channels) and gdf_mac_unit
`default_nettype none

// Holds a protein profile of MAX_LENGTH x 20 unsigned Q0.16 weights in a single-port
// memory (81920 x 16 at the default size, contents undefined until loaded, no clearing
// pass). A load transfer writes one weight and keeps req ready; loads with an out-of-range
// position or residue are dropped. A query transfer returns the Q12.32 sum over positions
// i of weight(i, head) * weight(i + gap + 1, tail) for i + gap + 1 < sequence_length.
// The sequencer reads the two weights through the one memory port, multiplies them and
// accumulates, in the states HEAD, TAIL, MUL and ACC for each term; with no terms or a
// residue out of range it goes straight to DONE (result zero). The request side is not
// ready while a query runs; it takes loads and the next query while a finished result
// still waits on the result channel. sequence_length is register 0 of the APB port (byte
// address 0); its low 13 bits are kept and saturated to MAX_LENGTH when used. The user
// must write it only while the block is idle; the block itself does not enforce this.
module gapped_dipeptide_frequency_unit import gdf_pkg::*; #(
   parameter int unsigned MAX_LENGTH = DEF_MAX_LENGTH
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   gdf_req_if.sink                    req,
   gdf_rsp_if.source                  rsp,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   localparam int unsigned DEPTH = MAX_LENGTH * RESIDUE_COUNT;
   localparam int unsigned ADDR_W = $clog2(DEPTH);
   localparam int unsigned LEN_MAX = (1 << LEN_W) - 1;
   localparam int unsigned LEN_CAP = (MAX_LENGTH < LEN_MAX) ? MAX_LENGTH : LEN_MAX;
   localparam logic [LEN_W-1:0] LEN_CAP_V = LEN_W'(LEN_CAP);
   localparam logic [RES_W-1:0] RES_LIMIT = RES_W'(RESIDUE_COUNT);

   // configuration
   logic [LEN_W-1:0] len_ff;
   logic [LEN_W-1:0] eff_len;
   logic             csr_write;

   assign csr_pready = 1'b1;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready
                      && (csr_paddr[2] == CSR_SEQUENCE_LENGTH);

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
      end else if (csr_write) begin
         len_ff <= csr_pwdata[LEN_W-1:0];
      end
   end

   always_comb begin
      if (csr_paddr[2] == CSR_SEQUENCE_LENGTH) begin
         csr_prdata = CSR_DATA_W'(len_ff);
      end else begin
         csr_prdata = '0;
      end
   end

   assign eff_len = (len_ff > LEN_CAP_V) ? LEN_CAP_V : len_ff;

   // sequencer state
   gdf_state_type    state_ff, state_in;
   logic [LEN_W-1:0] head_pos_ff, head_pos_in;
   logic [LEN_W-1:0] tail_pos_ff, tail_pos_in;
   logic [RES_W-1:0] head_res_ff, head_res_in;
   logic [RES_W-1:0] tail_res_ff, tail_res_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [SUM_W-1:0] rsp_sum_ff;
   logic             rsp_load;

   gdf_mac_ctrl_type    mac_ctrl;
   logic [SUM_W-1:0]    acc;

   logic                req_accept;
   logic                load_ok;
   logic                query_ok;
   logic [LEN_W-1:0]    tail_start;
   logic [LEN_W-1:0]    tail_next;
   logic                ram_we;
   logic [LEN_W-1:0]    ram_pos;
   logic [RES_W-1:0]    ram_res;
   logic [31:0]         ram_addr_full;
   logic [ADDR_W-1:0]   ram_addr;
   logic [WEIGHT_W-1:0] rdata_ff;
   logic [WEIGHT_W-1:0] profile_mem_ff [DEPTH];

   assign req.ready = (state_ff == ST_IDLE);
   assign req_accept = req.valid && req.ready;
   assign load_ok = (32'(req.position) < MAX_LENGTH) && (req.residue < RES_LIMIT);
   assign tail_start = LEN_W'(req.gap_length) + LEN_W'(1);
   assign query_ok = (req.head_residue < RES_LIMIT) && (req.tail_residue < RES_LIMIT)
                     && (tail_start < eff_len);
   assign tail_next = tail_pos_ff + LEN_W'(1);

   always_comb begin
      state_in = state_ff;
      head_pos_in = head_pos_ff;
      tail_pos_in = tail_pos_ff;
      head_res_in = head_res_ff;
      tail_res_in = tail_res_ff;
      mac_ctrl = '0;
      ram_we = 1'b0;
      ram_pos = head_pos_ff;
      ram_res = head_res_ff;
      rsp_load = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            ram_pos = LEN_W'(req.position);
            ram_res = req.residue;
            if (req_accept) begin
               if (req.kind == KIND_LOAD) begin
                  ram_we = load_ok;
               end else begin
                  mac_ctrl.clear = 1'b1;
                  head_pos_in = '0;
                  tail_pos_in = tail_start;
                  head_res_in = req.head_residue;
                  tail_res_in = req.tail_residue;
                  state_in = query_ok ? ST_HEAD : ST_DONE;
               end
            end
         end
         ST_HEAD: begin
            state_in = ST_TAIL;
         end
         ST_TAIL: begin
            // head weight is on the read port now, tail address goes out
            ram_pos = tail_pos_ff;
            ram_res = tail_res_ff;
            mac_ctrl.load_head = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            mac_ctrl.mult = 1'b1;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            mac_ctrl.accumulate = 1'b1;
            head_pos_in = head_pos_ff + LEN_W'(1);
            tail_pos_in = tail_next;
            state_in = (tail_next >= eff_len) ? ST_DONE : ST_HEAD;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      head_pos_ff <= head_pos_in;
      tail_pos_ff <= tail_pos_in;
      head_res_ff <= head_res_in;
      tail_res_ff <= tail_res_in;
   end

   // position * 20 + residue as two shifts and two adds
   assign ram_addr_full = (32'(ram_pos) << 4) + (32'(ram_pos) << 2) + 32'(ram_res);
   assign ram_addr = ram_addr_full[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (ram_we) begin
         profile_mem_ff[ram_addr] <= req.weight;
      end
      rdata_ff <= profile_mem_ff[ram_addr];
   end

   gdf_mac_unit u_mac (
      .clock (clock),
      .ctrl  (mac_ctrl),
      .rdata (rdata_ff),
      .acc   (acc)
   );

   // result register parts the sequencer from the result channel
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_sum_ff <= acc;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.frequency_sum = rsp_sum_ff;

   // a query with a bad residue skips the loop
   a_bad_residue_skips: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req.kind == KIND_QUERY)
       && ((req.head_residue >= RES_LIMIT) || (req.tail_residue >= RES_LIMIT)))
      |=> (state_ff == ST_DONE))
      else $error("query with bad residue entered the accumulate loop");

   // a result only appears from the done state
   a_result_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE))
      else $error("result raised outside the done state");

   // a load never produces a result
   a_load_no_result: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req.kind == KIND_LOAD) && !rsp_valid_ff) |=> !rsp_valid_ff)
      else $error("load transfer produced a result");

endmodule

`default_nettype wire
